// File: rtl/core/mpp_pkg.sv
// Package for the MPEG program stream PES packetizer.
// Holds the header byte constants, byte sequence positions and the job struct.
// No dependencies.
package mpp_pkg;

    localparam int DATA_W        = 8;
    localparam int SID_W         = 8;
    localparam int PTS_W         = 32;
    localparam int UNIT_FIELD_W  = 24;
    localparam int PLEN_W        = 16;
    localparam int POS_W         = 5;

    // tdata bit offsets on the input side
    localparam int IN_DATA_LSB   = 0;
    localparam int IN_SID_LSB    = 8;
    localparam int IN_PTS_LSB    = 16;
    localparam int IN_LEN_LSB    = 48;
    localparam int IN_TDATA_W    = 72;

    localparam int PES_FIXED_LEN = 9;
    localparam int PTS_FIELD_LEN = 5;
    localparam int PES_LEN_BASE  = 3;

    localparam int PACK_HDR_LEN  = 14;
    localparam logic [DATA_W-1:0] PACK_HDR [PACK_HDR_LEN] = '{
        8'h00, 8'h00, 8'h01, 8'hba, 8'h44, 8'h00, 8'h04, 8'h00,
        8'h04, 8'h01, 8'h01, 8'h86, 8'ha3, 8'hf8
    };

    localparam logic [DATA_W-1:0] START_CODE_0  = 8'h00;
    localparam logic [DATA_W-1:0] START_CODE_2  = 8'h01;
    localparam logic [DATA_W-1:0] PES_FLAGS_1   = 8'h81;
    localparam logic [DATA_W-1:0] PES_FLAGS_PTS = 8'h80;
    localparam logic [DATA_W-1:0] PES_ZERO      = 8'h00;
    localparam logic [3:0]        PTS_PREFIX    = 4'h2;

    // Positions in the per-item byte sequence
    typedef logic [POS_W-1:0] t_pos;
    localparam t_pos POS_PACK      = 5'd0;
    localparam t_pos POS_PACK_LAST = 5'd13;
    localparam t_pos POS_PES       = 5'd14;
    localparam t_pos POS_PES_SC1   = 5'd15;
    localparam t_pos POS_PES_SC2   = 5'd16;
    localparam t_pos POS_SID       = 5'd17;
    localparam t_pos POS_LEN_HI    = 5'd18;
    localparam t_pos POS_LEN_LO    = 5'd19;
    localparam t_pos POS_FLAGS1    = 5'd20;
    localparam t_pos POS_FLAGS2    = 5'd21;
    localparam t_pos POS_HDR_LEN   = 5'd22;
    localparam t_pos POS_PTS0      = 5'd23;
    localparam t_pos POS_PTS1      = 5'd24;
    localparam t_pos POS_PTS2      = 5'd25;
    localparam t_pos POS_PTS3      = 5'd26;
    localparam t_pos POS_PTS4      = 5'd27;
    localparam t_pos POS_PAYLOAD   = 5'd28;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              eou;
        logic              has_pts;
        logic [SID_W-1:0]  sid;
        logic [PLEN_W-1:0] plen;
        logic [PTS_W-1:0]  pts;
        t_pos              start_pos;
    } t_job;

endpackage

// File: rtl/core/mpp_emit.sv
// Byte sequencer and output register of the PES packetizer.
// Holds one job and walks it out byte by byte. Depends on mpp_pkg.
module mpp_emit
    import mpp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    input  t_job              i_job,
    output logic              o_job_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [DATA_W-1:0] o_out_byte,
    output logic              o_out_last,
    output logic              o_out_eou
);

    logic              r_busy;
    t_pos              r_pos;
    t_job              r_job;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_byte;
    logic              r_out_last;
    logic              r_out_eou;

    logic              out_load;
    logic              emit;
    logic              at_payload;
    logic              job_fire;
    logic [DATA_W-1:0] cur_byte;
    t_pos              n_pos;

    assign out_load    = !r_out_valid || i_out_ready;
    assign emit        = r_busy && out_load;
    assign at_payload  = (r_pos == POS_PAYLOAD);
    assign o_job_ready = !r_busy || (at_payload && out_load);
    assign job_fire    = i_job_valid && o_job_ready;

    // skip the PTS bytes on packets that carry none
    always_comb begin
        if (r_pos == POS_HDR_LEN && !r_job.has_pts) begin
            n_pos = POS_PAYLOAD;
        end else begin
            n_pos = r_pos + t_pos'(1);
        end
    end

    always_comb begin
        case (r_pos) inside
            [POS_PACK:POS_PACK_LAST]: cur_byte = PACK_HDR[r_pos[3:0]];
            POS_PES, POS_PES_SC1:     cur_byte = START_CODE_0;
            POS_PES_SC2:              cur_byte = START_CODE_2;
            POS_SID:                  cur_byte = r_job.sid;
            POS_LEN_HI:               cur_byte = r_job.plen[15:8];
            POS_LEN_LO:               cur_byte = r_job.plen[7:0];
            POS_FLAGS1:               cur_byte = PES_FLAGS_1;
            POS_FLAGS2:               cur_byte = r_job.has_pts ? PES_FLAGS_PTS : PES_ZERO;
            POS_HDR_LEN:              cur_byte = r_job.has_pts ?
                                          DATA_W'(PTS_FIELD_LEN) : PES_ZERO;
            POS_PTS0:                 cur_byte = {PTS_PREFIX, 1'b0, r_job.pts[31:30], 1'b1};
            POS_PTS1:                 cur_byte = r_job.pts[29:22];
            POS_PTS2:                 cur_byte = {r_job.pts[21:15], 1'b1};
            POS_PTS3:                 cur_byte = r_job.pts[14:7];
            POS_PTS4:                 cur_byte = {r_job.pts[6:0], 1'b1};
            POS_PAYLOAD:              cur_byte = r_job.data;
            default:                  cur_byte = PES_ZERO;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pos  <= POS_PAYLOAD;
        end else if (job_fire) begin
            r_busy <= 1'b1;
            r_pos  <= i_job.start_pos;
        end else if (emit && at_payload) begin
            r_busy <= 1'b0;
        end else if (emit) begin
            r_pos  <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (job_fire) begin
            r_job <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte <= cur_byte;
            r_out_last <= at_payload;
            r_out_eou  <= at_payload && r_job.eou;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;
    assign o_out_eou   = r_out_eou;

endmodule

// File: rtl/core/mpeg_pes_packetizer.sv
// Top level of the MPEG program stream PES packetizer.
// Tracks unit and packet byte counts and feeds jobs to mpp_emit. Depends on mpp_pkg and mpp_emit.
//
// Usage:
//   Slave channel: one payload byte of an access unit per transaction. On the
//   first byte of a unit the stream id, PTS and unit length are taken; on later
//   bytes those fields are ignored. A length of zero frames a one-byte unit.
//   Master channel: the framed program stream, one byte per transaction. tlast
//   marks the final byte caused by one input transaction (always the payload
//   byte), tuser marks the last payload byte of a unit.
//   The first output byte of an item passes the job register, then is loaded
//   into the output register, which drives it onto the master channel.
//   Output bytes: an item without header emits only its payload byte, an item
//   that opens a PES packet emits 10 bytes (9 header bytes and the payload
//   byte), and the first item of a unit emits 29 bytes (14-byte pack header,
//   14-byte PES header with PTS, payload byte). The byte sequencer in mpp_emit
//   drives one byte per cycle into the output register while it is not stalled.
//   Reset clears the counters, so the next byte opens a new unit. There is no
//   clearing pass. When the receiver stalls, the output register holds its
//   byte, the sequencer stops, and s_axis_tready drops once the job register
//   is full.
module mpeg_pes_packetizer
    import mpp_pkg::*;
#(
    parameter int PACKET_MAX    = 2048,
    parameter int UNIT_LEN_BITS = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [7:0] data_byte, [15:8] stream_id, [47:16] pts, [71:48] unit_length
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [7:0] out_byte
    output logic [DATA_W-1:0]     m_axis_tdata,
    output logic                  m_axis_tlast,
    // [0] end_of_unit
    output logic                  m_axis_tuser
);

    localparam int LEN_W = (UNIT_LEN_BITS < UNIT_FIELD_W) ? UNIT_LEN_BITS : UNIT_FIELD_W;
    // payload per packet stays below PACKET_MAX
    localparam int PKT_W = $clog2(PACKET_MAX);
    localparam int CMP_W = (UNIT_LEN_BITS > PKT_W) ? UNIT_LEN_BITS : PKT_W;
    localparam logic [CMP_W-1:0] CAP_FIRST =
        CMP_W'(PACKET_MAX - PES_FIXED_LEN - PTS_FIELD_LEN);
    localparam logic [CMP_W-1:0] CAP_LATER = CMP_W'(PACKET_MAX - PES_FIXED_LEN);

    logic [UNIT_LEN_BITS-1:0] r_unit_rem;
    logic [PKT_W-1:0]         r_pkt_rem;
    logic [SID_W-1:0]         r_sid;

    logic                     in_fire;
    logic                     unit_start;
    logic                     new_pkt;
    logic [UNIT_LEN_BITS-1:0] in_len;
    logic [UNIT_LEN_BITS-1:0] rem;
    logic [CMP_W-1:0]         rem_ext;
    logic [CMP_W-1:0]         cap;
    logic [PKT_W-1:0]         payload;
    logic [SID_W-1:0]         in_sid;
    t_job                     job;
    logic                     job_ready;

    assign in_fire    = s_axis_tvalid && s_axis_tready;
    assign unit_start = (r_unit_rem == '0);
    assign new_pkt    = unit_start || (r_pkt_rem == '0);
    assign in_sid     = s_axis_tdata[IN_SID_LSB +: SID_W];

    // mask the length to the unit counter width, saturate zero to one
    always_comb begin
        in_len = UNIT_LEN_BITS'(s_axis_tdata[IN_LEN_LSB +: LEN_W]);
        if (in_len == '0) begin
            in_len = UNIT_LEN_BITS'(1);
        end
    end

    assign rem     = unit_start ? in_len : r_unit_rem;
    assign rem_ext = CMP_W'(rem);
    assign cap     = unit_start ? CAP_FIRST : CAP_LATER;
    assign payload = PKT_W'((rem_ext < cap) ? rem_ext : cap);

    always_comb begin
        job.data      = s_axis_tdata[IN_DATA_LSB +: DATA_W];
        job.eou       = (rem == UNIT_LEN_BITS'(1));
        job.has_pts   = unit_start;
        job.sid       = unit_start ? in_sid : r_sid;
        job.plen      = PLEN_W'(payload) + (unit_start ?
                            PLEN_W'(PES_LEN_BASE + PTS_FIELD_LEN) : PLEN_W'(PES_LEN_BASE));
        job.pts       = s_axis_tdata[IN_PTS_LSB +: PTS_W];
        if (unit_start) begin
            job.start_pos = POS_PACK;
        end else if (new_pkt) begin
            job.start_pos = POS_PES;
        end else begin
            job.start_pos = POS_PAYLOAD;
        end
    end

    // advance the unit and packet counters per accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_rem <= '0;
            r_pkt_rem  <= '0;
            r_sid      <= '0;
        end else if (in_fire) begin
            r_unit_rem <= rem - UNIT_LEN_BITS'(1);
            r_pkt_rem  <= (new_pkt ? payload : r_pkt_rem) - PKT_W'(1);
            if (unit_start) begin
                r_sid <= in_sid;
            end
        end
    end

    assign s_axis_tready = job_ready;

    mpp_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (s_axis_tvalid),
        .i_job       (job),
        .o_job_ready (job_ready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_byte  (m_axis_tdata),
        .o_out_last  (m_axis_tlast),
        .o_out_eou   (m_axis_tuser)
    );

endmodule

// File: rtl/core/mpp_checker.sv
// Port-level checker for the PES packetizer, with its bind to the top level.
// Depends on mpp_pkg and mpeg_pes_packetizer.
module mpp_checker
    import mpp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [DATA_W-1:0]     m_axis_tdata,
    input  logic                  m_axis_tlast,
    input  logic                  m_axis_tuser
);

    // a stalled output transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("output changed while stalled");

    // end of unit only on a payload byte, which always closes the run
    a_eou_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("end of unit without tlast");

    // an accepted byte is followed by a valid output byte
    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> ##1 m_axis_tvalid)
        else $error("no output after input transaction");

    // reset leaves the output channel empty
    a_reset_empty: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind mpeg_pes_packetizer mpp_checker u_mpp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
